### hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hdl/tvn_pkg.sv
// Package for the turbulent value-noise texel block: constants and types.
// Depends on nothing.
package tvn_pkg;
  localparam int unsigned GainW    = 10;
  localparam int unsigned GainRegs = 6;
  localparam int unsigned MaxOct   = 8;
  localparam int unsigned AddrW    = 5;
  localparam logic [31:0] HashK1   = 32'd15731;
  localparam logic [31:0] HashK2   = 32'd789221;
  localparam logic [31:0] HashK3   = 32'd1376312589;

  typedef logic [GainW-1:0] gain_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_GAIN0 = 3'd0, REG_GAIN1 = 3'd1, REG_GAIN2 = 3'd2,
    REG_GAIN3 = 3'd3, REG_GAIN4 = 3'd4, REG_GAIN5 = 3'd5
  } reg_idx_e;

  localparam gain_t GainReset [GainRegs] = '{
    10'd410, 10'd307, 10'd205, 10'd102, 10'd179, 10'd26
  };
endpackage

### hdl/tvn_hash.sv
// Pipelined 31-bit integer hash, four register stages, with a side value.
// Depends on tvn_pkg for the hash constants.
module tvn_hash #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic [31:0]      v_i,
  input  logic [SideW-1:0] side_i,
  output logic [30:0]      h_o,
  output logic [SideW-1:0] side_o
);
  logic [31:0]      t_q, tt_q, t2_q, p_q, t3_q, h_q;
  logic [SideW-1:0] s1_q, s2_q, s3_q, s4_q;

  // t = v ^ (v << 13), then t*t, then *15731 + c, then t*p + c
  always_ff @(posedge clk_i) begin
    t_q  <= v_i ^ (v_i << 13);
    s1_q <= side_i;
    tt_q <= t_q * t_q;
    t2_q <= t_q;
    s2_q <= s1_q;
    p_q  <= tt_q * tvn_pkg::HashK1 + tvn_pkg::HashK2;
    t3_q <= t2_q;
    s3_q <= s2_q;
    h_q  <= t3_q * p_q + tvn_pkg::HashK3;
    s4_q <= s3_q;
  end

  assign h_o    = h_q[30:0];
  assign side_o = s4_q;
endmodule

### hdl/tvn_lattice.sv
// One lattice noise: three chained hash pipes.
// Depends on tvn_hash.
module tvn_lattice (
  input  logic        clk_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic [30:0] n_o
);
  logic [30:0] h1, h2;
  logic [31:0] y1;
  logic [0:0]  unused_s;

  tvn_hash #(.SideW(32)) u_h1 (.clk_i, .v_i(x_i), .side_i(y_i), .h_o(h1), .side_o(y1));
  tvn_hash #(.SideW(1)) u_h2 (
    .clk_i, .v_i(y1 + {24'd0, h1[30:23]}), .side_i(1'b0), .h_o(h2), .side_o(unused_s)
  );
  tvn_hash #(.SideW(1)) u_h3 (
    .clk_i, .v_i({24'd0, h2[30:23]}), .side_i(unused_s), .h_o(n_o), .side_o()
  );
endmodule

### hdl/turbulent_value_noise_texel.sv
// Turbulent value-noise texel generator, top level.
// A transaction runs from start to result_valid_o; one transaction per cycle.
// The path runs through three chained four-stage hash pipes plus sum,
// weighting, accumulation and scaling stages. busy_o is always low.
// Reset (rst_ni low, asynchronous) clears valid bits and restores gains.
module turbulent_value_noise_texel #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned OCTAVES    = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  output logic                  result_valid_o,
  output logic [15:0]           noise_value_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [tvn_pkg::AddrW-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int unsigned Lat  = 12;
  localparam int unsigned Div  = 5 * OCTAVES;
  // acc/(Div*2^23): accumulate fits 31+3+10+3 bits
  localparam int unsigned AccW = 48;
  // Reciprocal of Div, exact for quotients of a 25-bit value by Div <= 40
  localparam int unsigned RecipShift = 31;
  localparam logic [30:0] Recip =
    31'(((64'd1 << RecipShift) + 64'(Div) - 64'd1) / 64'(Div));

  tvn_pkg::gain_t gain_q [tvn_pkg::GainRegs];
  logic [2:0] widx;
  assign widx   = paddr[4:2];
  assign pready = 1'b1;
  assign busy_o = 1'b0;

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= tvn_pkg::GainReset;
    end else if (psel && penable && pwrite) begin
      for (int i = 0; i < tvn_pkg::GainRegs; i++)
        if (widx == 3'(i)) gain_q[i] <= pwdata[tvn_pkg::GainW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < tvn_pkg::GainRegs; i++)
      if (widx == 3'(i) && paddr[1:0] == 2'b00) prdata = {22'd0, gain_q[i]};
  end

  // Valid shift line matching the lattice latency plus 4 tail stages
  logic [Lat+3:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat+2:0], start_i};
  end

  logic [33:0] sum_q [OCTAVES];
  logic [43:0] prod_q [OCTAVES];
  logic [AccW-1:0] acc_q;
  logic [15:0] res_q;

  // Per octave: five lattice pipes, a five-way sum and the gain weighting
  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    logic [31:0] x, y;
    logic [30:0] n [5];
    assign x = 32'(pixel_x_i >> o);
    assign y = 32'(pixel_y_i >> o);
    tvn_lattice u_l0 (.clk_i, .x_i(x),         .y_i(y),         .n_o(n[0]));
    tvn_lattice u_l1 (.clk_i, .x_i(x + 32'd1), .y_i(y),         .n_o(n[1]));
    tvn_lattice u_l2 (.clk_i, .x_i(x - 32'd1), .y_i(y),         .n_o(n[2]));
    tvn_lattice u_l3 (.clk_i, .x_i(x),         .y_i(y + 32'd1), .n_o(n[3]));
    tvn_lattice u_l4 (.clk_i, .x_i(x),         .y_i(y - 32'd1), .n_o(n[4]));
    always_ff @(posedge clk_i) begin
      sum_q[o] <= 34'(n[0]) + 34'(n[1]) + 34'(n[2]) + 34'(n[3]) + 34'(n[4]);
      prod_q[o] <= 44'(sum_q[o]) *
                   ((o < tvn_pkg::GainRegs) ? 44'(gain_q[o % tvn_pkg::GainRegs]) : 44'd0);
    end
  end

  // Accumulate octaves, then divide by constant and saturate
  logic [AccW-1:0] acc_d;
  logic [AccW-24:0] acc_hi;
  logic [AccW+7:0] q_prod;
  logic [AccW-24:0] q;
  always_comb begin
    acc_d = '0;
    for (int o = 0; o < OCTAVES; o++) acc_d = acc_d + AccW'(prod_q[o]);
  end
  // floor(acc / (Div*2^23)) = floor((acc >> 23) / Div), by reciprocal multiply
  assign acc_hi = acc_q[AccW-1:23];
  assign q_prod = (AccW+8)'(acc_hi) * (AccW+8)'(Recip);
  assign q      = q_prod[AccW+7:RecipShift];

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    res_q <= (q > 25'd65535) ? 16'hFFFF : q[15:0];
  end

  assign result_valid_o = vld_q[Lat+3];
  assign noise_value_o  = res_q;
endmodule

### hdl/tvn_checker.sv
// Port-level checker for the texel block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module tvn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o,
  input logic pready
);
  `ASSERT_IMPL(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o, "busy raised")
  `ASSERT_IMPL(a_ready, clk_i, rst_ni, 1'b1, pready, "pready low")
  `ASSERT_IMPL(a_lat, clk_i, rst_ni, $past(start_i, 16) && $past(rst_ni, 16),
    result_valid_o, "result missing after 16 cycles")
endmodule

bind turbulent_value_noise_texel tvn_checker u_chk (.*);

### tb/tb_turbulent_value_noise_texel.sv
// Self-checking testbench for the turbulent value-noise texel generator.
// Depends on tvn_pkg and turbulent_value_noise_texel; computes expected texels itself.
module tb_turbulent_value_noise_texel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned NumOct  = 6;
  localparam int unsigned Latency = 16;
  localparam int unsigned NumRand = 850;
  localparam longint unsigned CycleLimit = 200000;
  localparam int unsigned AddrW   = tvn_pkg::AddrW;
  localparam int unsigned GainW   = tvn_pkg::GainW;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [CoordW-1:0] pixel_x_i = '0;
  logic [CoordW-1:0] pixel_y_i = '0;
  logic        result_valid_o;
  logic [15:0] noise_value_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  turbulent_value_noise_texel #(.COORD_BITS(CoordW), .OCTAVES(NumOct)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .pixel_x_i, .pixel_y_i,
    .result_valid_o, .noise_value_o, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the gain registers
  tvn_pkg::gain_t gain_shadow [tvn_pkg::GainRegs];
  logic [15:0] texel_q [$];
  int unsigned errors = 0;
  int unsigned texels_seen = 0;
  longint unsigned cycles = 0;

  function automatic logic [30:0] hash31(logic [31:0] v);
    logic [31:0] t, p;
    t = (v << 13) ^ v;
    p = t * t;
    p = p * tvn_pkg::HashK1 + tvn_pkg::HashK2;
    p = t * p + tvn_pkg::HashK3;
    return p[30:0];
  endfunction

  function automatic logic [30:0] lattice_val(logic [31:0] x, logic [31:0] y);
    logic [31:0] sy, sz;
    sy = 32'(hash31(x) >> 23);
    sz = 32'(hash31(y + sy) >> 23);
    return hash31(sz);
  endfunction

  function automatic logic [15:0] turbulence(logic [CoordW-1:0] px, logic [CoordW-1:0] py);
    logic [63:0] acc, s, q;
    logic [31:0] x, y;
    acc = '0;
    for (int i = 0; i < NumOct; i++) begin
      x = 32'(px) >> i;
      y = 32'(py) >> i;
      s = 64'(lattice_val(x, y)) + 64'(lattice_val(x + 1, y))
        + 64'(lattice_val(x - 1, y)) + 64'(lattice_val(x, y + 1))
        + 64'(lattice_val(x, y - 1));
      acc += s * 64'(gain_shadow[i]);
    end
    q = acc / ((64'd5 * NumOct) << 23);
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Result checking at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) begin
      texels_seen <= texels_seen + 1;
      if (texel_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected texel %0d", noise_value_o);
      end else begin
        logic [15:0] exp_v;
        exp_v = texel_q.pop_front();
        if (exp_v !== noise_value_o) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("texel mismatch: expected %0d got %0d", exp_v, noise_value_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("tb_turbulent_value_noise_texel: errors");
      $finish;
    end
  end

  task automatic write_gain(tvn_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrW'(4 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    gain_shadow[idx] = val[GainW-1:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drive one transaction; exp_fixed < 0 means use the predictor
  task automatic send_texel(logic [CoordW-1:0] px, logic [CoordW-1:0] py,
                            int exp_fixed, bit idle_ok);
    int gap;
    logic [15:0] exp_new;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1; pixel_x_i <= px; pixel_y_i <= py;
    do @(posedge clk_i); while (busy_o);
    exp_new = (exp_fixed >= 0) ? 16'(exp_fixed) : turbulence(px, py);
    texel_q = {texel_q, exp_new};
    @(negedge clk_i);
  endtask

  // Called at a falling edge: stop sending at once, then wait for results
  task automatic drain();
    start_i <= 1'b0;
    while (texel_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  typedef struct {
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    int                exp_v;
  } texel_row_t;

  // Directed rows: corners, edges (wrap of x-1 / y-1), alternating bits
  texel_row_t dir_tab [] = '{
    '{12'd0,    12'd0,    -1}, '{12'hFFF, 12'hFFF, -1}, '{12'd0,    12'hFFF, -1},
    '{12'hFFF, 12'd0,    -1}, '{12'h555, 12'hAAA, -1}, '{12'hAAA, 12'h555, -1},
    '{12'd1,    12'd1,    -1}, '{12'd0,    12'd37,   -1}, '{12'd63,   12'd0,    -1},
    '{12'h800, 12'h7FF, -1}
  };

  initial begin
    for (int i = 0; i < tvn_pkg::GainRegs; i++) gain_shadow[i] = tvn_pkg::GainReset[i];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset gains
    foreach (dir_tab[k]) send_texel(dir_tab[k].px, dir_tab[k].py, dir_tab[k].exp_v, 1'b0);
    drain();

    // All gains zero: result must be zero
    for (int i = 0; i < tvn_pkg::GainRegs; i++)
      write_gain(tvn_pkg::reg_idx_e'(i), 32'hFFFF_FC00);
    send_texel(12'd0, 12'd0, 0, 1'b0);
    send_texel(12'hFFF, 12'hFFF, 0, 1'b0);
    drain();

    // All gains max: saturation likely
    for (int i = 0; i < tvn_pkg::GainRegs; i++) write_gain(tvn_pkg::reg_idx_e'(i), 32'h3FF);
    foreach (dir_tab[k]) send_texel(dir_tab[k].px, dir_tab[k].py, -1, 1'b0);
    drain();

    // Random phases with random gains; sender waits for drain between phases
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < tvn_pkg::GainRegs; i++) begin
        case ($urandom_range(0, 3))
          0: write_gain(tvn_pkg::reg_idx_e'(i), 32'h0);
          1: write_gain(tvn_pkg::reg_idx_e'(i), 32'h3FF);
          default: write_gain(tvn_pkg::reg_idx_e'(i), $urandom);
        endcase
      end
      for (int n = 0; n < NumRand / 5; n++)
        send_texel(CoordW'($urandom), CoordW'($urandom), -1, ph < 4);
      drain();
    end

    $display("covered %0d texels over reset, zero, full and random gain settings",
             texels_seen);
    if (errors == 0) $display("tb_turbulent_value_noise_texel: clean");
    else $display("tb_turbulent_value_noise_texel: errors");
    $finish;
  end
endmodule
